// ===== design/sqe_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sqe_pkg
// Shared types and constants for the segment to quad expander pipeline.
// ----------------------------------------------------------------------------
package sqe_pkg;

  localparam int unsigned CoordW = 16;
  localparam int unsigned HwW    = 12;
  localparam int unsigned WideW  = 64;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic [HwW-1:0]           hw_t;
  typedef logic [WideW-1:0]         wide_t;

  typedef struct packed {
    coord_t sx;
    coord_t sy;
    coord_t ex;
    coord_t ey;
    logic   neg_ox;
    logic   neg_oy;
  } geo_t;

  typedef struct packed {
    hw_t   q;
    wide_t p;
    wide_t s;
  } acc_t;

  typedef struct packed {
    logic  valid;
    geo_t  geo;
    wide_t sq;
    wide_t rx;
    wide_t ry;
    acc_t  ax;
    acc_t  ay;
  } srch_t;

  function automatic coord_t sat(input logic signed [CoordW+1:0] v);
    logic signed [CoordW+1:0] hi;
    logic signed [CoordW+1:0] lo;
    hi = (CoordW+2)'(2**(CoordW-1) - 1);
    lo = -hi - (CoordW+2)'(1);
    if (v > hi) begin
      sat = coord_t'(hi);
    end else if (v < lo) begin
      sat = coord_t'(lo);
    end else begin
      sat = coord_t'(v);
    end
  endfunction

endpackage
`default_nettype wire

// ===== design/sqe_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sqe_front
// Direction, squared length and squared scaled magnitudes over three stages.
// ----------------------------------------------------------------------------
module sqe_front (
  input  wire            clk,
  input  wire            rst,
  input  wire            in_valid,
  input  sqe_pkg::geo_t  in_geo,
  input  sqe_pkg::hw_t   in_hw,
  output sqe_pkg::srch_t out
);
  import sqe_pkg::*;

  logic             v1;
  geo_t             g1;
  hw_t              hw1;
  logic signed [16:0] dx1;
  logic signed [16:0] dy1;

  logic             v2;
  geo_t             g2;
  logic [31:0]      ax2;
  logic [31:0]      ay2;
  logic [23:0]      hw2;

  logic signed [16:0] dx_next;
  logic signed [16:0] dy_next;
  geo_t               g_next;
  logic [15:0]        abx;
  logic [15:0]        aby;
  logic [55:0]        px;
  logic [55:0]        py;

  assign dx_next = 17'(in_geo.ex) - 17'(in_geo.sx);
  assign dy_next = 17'(in_geo.ey) - 17'(in_geo.sy);
  assign abx = dx1[16] ? 16'(-dx1) : 16'(dx1);
  assign aby = dy1[16] ? 16'(-dy1) : 16'(dy1);
  assign px = ax2 * hw2;
  assign py = ay2 * hw2;

  always_comb begin
    g_next = in_geo;
    g_next.neg_ox = dy_next > 0;
    g_next.neg_oy = dx_next < 0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      out.valid <= 1'b0;
    end else begin
      v1 <= in_valid && (dx_next != '0 || dy_next != '0);
      v2 <= v1;
      out.valid <= v2;
    end
    g1 <= g_next;
    hw1 <= in_hw;
    dx1 <= dx_next;
    dy1 <= dy_next;
    g2 <= g1;
    ax2 <= abx * abx;
    ay2 <= aby * aby;
    hw2 <= hw1 * hw1;
    out.geo <= g2;
    out.sq <= WideW'(ax2) + WideW'(ay2);
    out.rx <= WideW'({px, 2'b00});
    out.ry <= WideW'({py, 2'b00});
    out.ax <= '0;
    out.ay <= '0;
  end

endmodule
`default_nettype wire

// ===== design/sqe_search_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sqe_search_stage
// One bit of the rounded ratio search for both offset magnitudes.
// ----------------------------------------------------------------------------
module sqe_search_stage #(
  parameter int unsigned BIT = 0
) (
  input  wire            clk,
  input  wire            rst,
  input  sqe_pkg::srch_t in,
  output sqe_pkg::srch_t out
);
  import sqe_pkg::*;

  function automatic acc_t step(input acc_t a, input wide_t sq, input wide_t r);
    acc_t  n;
    wide_t cand;
    n.q = a.q | hw_t'(1 << BIT);
    n.p = a.p + (a.s << (BIT + 1)) + (sq << (2 * BIT));
    n.s = a.s + (sq << BIT);
    cand = (n.p << 2) - (n.s << 2) + sq;
    step = (cand <= r) ? n : a;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      out.valid <= 1'b0;
    end else begin
      out.valid <= in.valid;
    end
    out.geo <= in.geo;
    out.sq <= in.sq;
    out.rx <= in.rx;
    out.ry <= in.ry;
    out.ax <= step(in.ax, in.sq, in.rx);
    out.ay <= step(in.ay, in.sq, in.ry);
  end

endmodule
`default_nettype wire

// ===== design/sqe_corner.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sqe_corner
// Signed offsets, corner sums with saturation and the result register.
// ----------------------------------------------------------------------------
module sqe_corner (
  input  wire             clk,
  input  wire             rst,
  input  sqe_pkg::srch_t  in,
  output logic            done,
  output sqe_pkg::coord_t c1x,
  output sqe_pkg::coord_t c1y,
  output sqe_pkg::coord_t c2x,
  output sqe_pkg::coord_t c2y,
  output sqe_pkg::coord_t c3x,
  output sqe_pkg::coord_t c3y,
  output sqe_pkg::coord_t c4x,
  output sqe_pkg::coord_t c4y
);
  import sqe_pkg::*;

  logic signed [CoordW+1:0] ox;
  logic signed [CoordW+1:0] oy;
  logic signed [CoordW+1:0] sx;
  logic signed [CoordW+1:0] sy;
  logic signed [CoordW+1:0] ex;
  logic signed [CoordW+1:0] ey;

  assign ox = in.geo.neg_ox ? -$signed((CoordW+2)'(in.ay.q)) : $signed((CoordW+2)'(in.ay.q));
  assign oy = in.geo.neg_oy ? -$signed((CoordW+2)'(in.ax.q)) : $signed((CoordW+2)'(in.ax.q));
  assign sx = (CoordW+2)'(in.geo.sx);
  assign sy = (CoordW+2)'(in.geo.sy);
  assign ex = (CoordW+2)'(in.geo.ex);
  assign ey = (CoordW+2)'(in.geo.ey);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in.valid;
    end
    c1x <= sat(sx + ox);
    c1y <= sat(sy + oy);
    c2x <= sat(ex + ox);
    c2y <= sat(ey + oy);
    c3x <= sat(ex - ox);
    c3y <= sat(ey - oy);
    c4x <= sat(sx - ox);
    c4y <= sat(sy - oy);
  end

endmodule
`default_nettype wire

// ===== design/segment_to_quad_expander.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// segment_to_quad_expander
// Thickens a 2-D segment into a quad of four saturated corners.
//
// Request channel: start with start_x/y, end_x/y and half_width; a request
// is taken at every rising edge with start high and busy low. busy is
// always low, so one request enters every cycle.
// Result channel: done is high for one cycle with corner1..corner4; the
// receiver takes it at the end of that cycle and cannot stall.
// Pipeline: 3 front stages, 12 search stages and the corner register
// between request and done. Throughput: one request a cycle.
// A zero-length segment gives no result. Reset clears all valid bits; no
// result appears for requests taken before reset.
// ----------------------------------------------------------------------------
module segment_to_quad_expander (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    start,
  output logic                   busy,
  input  wire signed [15:0]      start_x,
  input  wire signed [15:0]      start_y,
  input  wire signed [15:0]      end_x,
  input  wire signed [15:0]      end_y,
  input  wire [11:0]             half_width,
  output logic                   done,
  output logic signed [15:0]     corner1_x,
  output logic signed [15:0]     corner1_y,
  output logic signed [15:0]     corner2_x,
  output logic signed [15:0]     corner2_y,
  output logic signed [15:0]     corner3_x,
  output logic signed [15:0]     corner3_y,
  output logic signed [15:0]     corner4_x,
  output logic signed [15:0]     corner4_y
);
  import sqe_pkg::*;

  geo_t  geo_in;
  srch_t chain [0:HwW];

  assign busy = 1'b0;
  assign geo_in = '{sx: start_x, sy: start_y, ex: end_x, ey: end_y,
                    neg_ox: 1'b0, neg_oy: 1'b0};

  sqe_front u_front (
    .clk(clk), .rst(rst), .in_valid(start && !busy), .in_geo(geo_in),
    .in_hw(half_width), .out(chain[0])
  );

  for (genvar i = 0; i < HwW; i++) begin : g_srch
    sqe_search_stage #(.BIT(HwW - 1 - i)) u_stage (
      .clk(clk), .rst(rst), .in(chain[i]), .out(chain[i+1])
    );
  end

  sqe_corner u_corner (
    .clk(clk), .rst(rst), .in(chain[HwW]), .done(done),
    .c1x(corner1_x), .c1y(corner1_y), .c2x(corner2_x), .c2y(corner2_y),
    .c3x(corner3_x), .c3y(corner3_y), .c4x(corner4_x), .c4y(corner4_y)
  );

endmodule
`default_nettype wire
